// ===== rtl/tls_record_size_shaper_defines.svh =====
// Shared assertion macros for the record size shaper.
`ifndef TLS_RECORD_SIZE_SHAPER_DEFINES_SVH
`define TLS_RECORD_SIZE_SHAPER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define TRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/trs_pkg.sv =====
`default_nettype none
package trs_pkg;

  localparam logic KIND_SEND  = 1'b0;
  localparam logic KIND_TIMER = 1'b1;

  localparam logic CFG_IDX_TLS_MODE  = 1'b0;
  localparam logic CFG_IDX_DELAYS_EN = 1'b1;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [5:0]  PHASE1_RECORDS = 6'd40;
  localparam logic [5:0]  PHASE2_RECORDS = 6'd60;
  localparam logic [5:0]  COUNT_MAX      = 6'd63;
  localparam logic [5:0]  PAUSE_RECORDS  = 6'd1;
  localparam logic [14:0] SIZE_START     = 15'd1450;
  localparam logic [14:0] SIZE_ACCEL     = 15'd4096;
  localparam logic [14:0] SIZE_MAX_REC   = 15'd16144;
  localparam logic [14:0] NOISE_BIAS     = 15'd100;
  localparam logic [14:0] SIZE_FLOOR     = 15'd64;
  localparam logic [7:0]  NOISE_SPAN     = 8'd201;
  localparam logic [31:0] RESET_GAP_MS   = 32'd1000;
  localparam logic [31:0] BURST_GAP_MS   = 32'd30000;

  typedef struct packed {
    logic tls_mode;
    logic delays_enabled;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] bytes_pending;
    logic [31:0] now_ms;
    logic [7:0]  noise_draw;
  } in_item_t;

  typedef struct packed {
    logic [23:0] record_length;
    logic        with_header;
    logic [23:0] bytes_left;
    logic        delay_request;
    logic        held;
  } out_item_t;

  function automatic logic [5:0] count_up(input logic [5:0] v);
    count_up = (v == COUNT_MAX) ? COUNT_MAX : v + 6'd1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/trs_in_if.sv =====
`default_nettype none
interface trs_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [23:0] bytes_pending;
  logic [31:0] now_ms;
  logic [7:0]  noise_draw;

  modport source (output valid, kind, bytes_pending, now_ms, noise_draw, input ready);
  modport sink (input valid, kind, bytes_pending, now_ms, noise_draw, output ready);
endinterface
`default_nettype wire

// ===== rtl/trs_out_if.sv =====
`default_nettype none
interface trs_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] record_length;
  logic        with_header;
  logic [23:0] bytes_left;
  logic        delay_request;
  logic        held;

  modport source (output valid, record_length, with_header, bytes_left, delay_request, held,
                  input ready);
  modport sink (input valid, record_length, with_header, bytes_left, delay_request, held,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/trs_cfg_regs.sv =====
`default_nettype none
module trs_cfg_regs
  import trs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic tls_mode_r, tls_mode_nxt;
  logic delays_en_r, delays_en_nxt;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    tls_mode_nxt  = tls_mode_r;
    delays_en_nxt = delays_en_r;
    if (wr_en) begin
      case (reg_idx)
        CFG_IDX_TLS_MODE:  tls_mode_nxt  = pwdata[0];
        CFG_IDX_DELAYS_EN: delays_en_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tls_mode_r  <= 1'b1;
      delays_en_r <= 1'b0;
    end else begin
      tls_mode_r  <= tls_mode_nxt;
      delays_en_r <= delays_en_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      CFG_IDX_TLS_MODE:  prdata[0] = tls_mode_r;
      CFG_IDX_DELAYS_EN: prdata[0] = delays_en_r;
      default: ;
    endcase
  end

  assign cfg.tls_mode       = tls_mode_r;
  assign cfg.delays_enabled = delays_en_r;

endmodule
`default_nettype wire

// ===== rtl/trs_in_stage.sv =====
`default_nettype none
module trs_in_stage
  import trs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     in_fire;

  assign in_ready = !valid_r || take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ===== rtl/trs_shaper_core.sv =====
`default_nettype none
`include "tls_record_size_shaper_defines.svh"
module trs_shaper_core
  import trs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire in_item_t  item,
  input  wire logic      fire,
  output out_item_t      result
);

  logic [5:0]  record_count_r, record_count_nxt;
  logic [5:0]  burst_total_r, burst_total_nxt;
  logic [31:0] last_send_r, last_send_nxt;
  logic        pause_r, pause_nxt;

  logic [31:0] gap;
  logic        idle_gap;
  logic        burst_gap;
  logic [5:0]  rc_base;
  logic [5:0]  bt_base;
  logic [5:0]  rc_up;
  logic [5:0]  bt_up;
  logic [7:0]  noise_mod;
  logic [14:0] base_size;
  logic [14:0] raw_limit;
  logic [14:0] limit;
  logic [23:0] limit_ext;
  logic [23:0] send_len;
  logic [23:0] send_left;
  logic        raise_pause;

  // Shaping path, valid when the item is a framed send with data.
  assign gap       = item.now_ms - last_send_r;
  assign idle_gap  = gap > RESET_GAP_MS;
  assign burst_gap = gap > BURST_GAP_MS;
  assign rc_base   = idle_gap ? 6'd0 : record_count_r;
  assign bt_base   = burst_gap ? 6'd0 : burst_total_r;
  assign rc_up     = count_up(rc_base);
  assign bt_up     = count_up(bt_base);

  // The draw stays below twice the span, so one subtraction reduces it.
  assign noise_mod = (item.noise_draw >= NOISE_SPAN) ? item.noise_draw - NOISE_SPAN
                                                     : item.noise_draw;

  always_comb begin
    if (rc_base < PHASE1_RECORDS) begin
      base_size = SIZE_START;
    end else if (rc_base < PHASE2_RECORDS) begin
      base_size = SIZE_ACCEL;
    end else begin
      base_size = SIZE_MAX_REC;
    end
  end

  assign raw_limit = base_size + {7'd0, noise_mod} - NOISE_BIAS;
  assign limit     = (raw_limit < SIZE_FLOOR) ? SIZE_FLOOR : raw_limit;
  assign limit_ext = {9'd0, limit};
  assign send_len  = (limit_ext < item.bytes_pending) ? limit_ext : item.bytes_pending;
  assign send_left = item.bytes_pending - send_len;

  assign raise_pause = cfg.delays_enabled && (send_left != 24'd0) &&
                       (send_left <= {9'd0, SIZE_MAX_REC}) &&
                       (bt_up < PHASE2_RECORDS) && (rc_up <= PAUSE_RECORDS);

  always_comb begin
    record_count_nxt = record_count_r;
    burst_total_nxt  = burst_total_r;
    last_send_nxt    = last_send_r;
    pause_nxt        = pause_r;
    result           = '0;
    if (item.kind == KIND_TIMER) begin
      pause_nxt         = 1'b0;
      result.bytes_left = item.bytes_pending;
    end else if (cfg.tls_mode && pause_r) begin
      result.held       = 1'b1;
      result.bytes_left = item.bytes_pending;
    end else if (item.bytes_pending == 24'd0) begin
      result = '0;
    end else if (!cfg.tls_mode) begin
      result.record_length = item.bytes_pending;
    end else begin
      result.record_length = send_len;
      result.with_header   = 1'b1;
      result.bytes_left    = send_left;
      result.delay_request = raise_pause;
      record_count_nxt     = rc_up;
      burst_total_nxt      = bt_up;
      last_send_nxt        = item.now_ms;
      pause_nxt            = raise_pause || (pause_r && !idle_gap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_count_r <= '0;
      burst_total_r  <= '0;
      last_send_r    <= '0;
      pause_r        <= 1'b0;
    end else if (fire) begin
      record_count_r <= record_count_nxt;
      burst_total_r  <= burst_total_nxt;
      last_send_r    <= last_send_nxt;
      pause_r        <= pause_nxt;
    end
  end

  `TRS_ASSERT_NEXT(a_timer_clears_pause, clk, rst_n, fire && (item.kind == KIND_TIMER), !pause_r)
  `TRS_ASSERT_NEXT(a_request_sets_pause, clk, rst_n, fire && result.delay_request,
                   pause_r && (record_count_r <= PAUSE_RECORDS))
  `TRS_ASSERT_NOW(a_framed_len_adds_up, clk, rst_n, fire && result.with_header,
                  (result.record_length + result.bytes_left) == item.bytes_pending)
  `TRS_ASSERT_NEXT(a_counts_hold_when_idle, clk, rst_n, !fire,
                   $stable(record_count_r) && $stable(burst_total_r) && $stable(pause_r))

endmodule
`default_nettype wire

// ===== rtl/trs_out_stage.sv =====
`default_nettype none
module trs_out_stage
  import trs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_item_t res_in,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ===== rtl/tls_record_size_shaper.sv =====
// Channel   Direction  Handshake        Word
// in_chan   input      valid / ready    kind, bytes_pending, now_ms, noise_draw
// out_chan  output     valid / ready    record_length, with_header, bytes_left,
//                                       delay_request, held
// cfg_*     input      APB write/read   tls_mode (0x0), delays_enabled (0x4)
//
// One word is accepted per cycle unless the result register stalls.
// The decision and the shaper state update happen in the same cycle between the
// input register and the result register, so each word sees the state left
// by the word before it. A stalled result register stops the input register,
// and the input side keeps taking words while the result register drains.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none
module tls_record_size_shaper
  import trs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  trs_in_if.sink                     in_chan,
  trs_out_if.source                  out_chan,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      s1_take;
  logic      out_free;
  out_item_t core_res;
  out_item_t out_item;

  assign in_item.kind          = in_chan.kind;
  assign in_item.bytes_pending = in_chan.bytes_pending;
  assign in_item.now_ms        = in_chan.now_ms;
  assign in_item.noise_draw    = in_chan.noise_draw;

  assign s1_take = s1_valid && out_free;

  trs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  trs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_item),
    .take       (s1_take),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  trs_shaper_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (s1_item),
    .fire   (s1_take),
    .result (core_res)
  );

  trs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_take),
    .res_in    (core_res),
    .free      (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  assign out_chan.record_length = out_item.record_length;
  assign out_chan.with_header   = out_item.with_header;
  assign out_chan.bytes_left    = out_item.bytes_left;
  assign out_chan.delay_request = out_item.delay_request;
  assign out_chan.held          = out_item.held;

endmodule
`default_nettype wire
